/* rtl/hsv2rgb_pkg.sv */
package hsv2rgb_pkg;

  // Fixed-point constants of the conversion.
  localparam int unsigned SectorDeg   = 60;
  localparam int unsigned FullScale   = 255;
  localparam int unsigned FullCircle  = 360;
  localparam int unsigned SectorScale = SectorDeg * FullScale;

  // Field widths.
  localparam int unsigned HueW   = 9;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned SecW   = 3;
  localparam int unsigned FracW  = 6;
  localparam int unsigned SfW    = 14;
  localparam int unsigned PNumW  = 16;
  localparam int unsigned QNumW  = 22;

  // Reciprocal for the division by 255 of a 16-bit numerator.
  localparam int unsigned     PShift   = 24;
  localparam int unsigned     PRecipW  = 17;
  localparam longint unsigned PRecipL  =
    ((64'd1 << PShift) + 64'(FullScale) - 64'd1) / 64'(FullScale);
  localparam logic [PRecipW-1:0] PRecip = PRecipW'(PRecipL);
  localparam int unsigned     PProdW   = PNumW + PRecipW;

  // Reciprocal for the division by 15300 of a 22-bit numerator.
  localparam int unsigned     QShift   = 36;
  localparam int unsigned     QRecipW  = 23;
  localparam longint unsigned QRecipL  =
    ((64'd1 << QShift) + 64'(SectorScale) - 64'd1) / 64'(SectorScale);
  localparam logic [QRecipW-1:0] QRecip = QRecipW'(QRecipL);
  localparam int unsigned     QProdW   = QNumW + QRecipW;

  // Hue sector codes.
  localparam logic [SecW-1:0] SEC_0 = 3'd0;
  localparam logic [SecW-1:0] SEC_1 = 3'd1;
  localparam logic [SecW-1:0] SEC_2 = 3'd2;
  localparam logic [SecW-1:0] SEC_3 = 3'd3;
  localparam logic [SecW-1:0] SEC_4 = 3'd4;
  localparam logic [SecW-1:0] SEC_5 = 3'd5;

  // Item after the hue has been split into sector and fraction.
  typedef struct packed {
    logic              valid;
    logic [SecW-1:0]   sector;
    logic [FracW-1:0]  frac;
    logic [ChanW-1:0]  sat;
    logic [ChanW-1:0]  val;
  } sec_item_t;

  // Item carrying the three derived levels.
  typedef struct packed {
    logic              valid;
    logic [SecW-1:0]   sector;
    logic [ChanW-1:0]  val;
    logic [ChanW-1:0]  p;
    logic [ChanW-1:0]  q;
    logic [ChanW-1:0]  t;
  } lvl_item_t;

endpackage

/* rtl/hsv2rgb_sector.sv */
module hsv2rgb_sector
  import hsv2rgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [HueW-1:0]  hue,
  input  logic [ChanW-1:0] saturation,
  input  logic [ChanW-1:0] brightness,
  output sec_item_t        sec_out
);

  logic [HueW-1:0] hue_wrap;
  logic [HueW-1:0] base;
  logic [SecW-1:0] sector_next;

  // Wrap hues beyond the full circle back onto it.
  assign hue_wrap = (hue >= HueW'(FullCircle)) ? hue - HueW'(FullCircle) : hue;

  // Find the 60-degree sector and its starting angle.
  always_comb begin
    priority if (hue_wrap >= HueW'(5 * SectorDeg)) begin
      sector_next = SEC_5;
      base        = HueW'(5 * SectorDeg);
    end else if (hue_wrap >= HueW'(4 * SectorDeg)) begin
      sector_next = SEC_4;
      base        = HueW'(4 * SectorDeg);
    end else if (hue_wrap >= HueW'(3 * SectorDeg)) begin
      sector_next = SEC_3;
      base        = HueW'(3 * SectorDeg);
    end else if (hue_wrap >= HueW'(2 * SectorDeg)) begin
      sector_next = SEC_2;
      base        = HueW'(2 * SectorDeg);
    end else if (hue_wrap >= HueW'(SectorDeg)) begin
      sector_next = SEC_1;
      base        = HueW'(SectorDeg);
    end else begin
      sector_next = SEC_0;
      base        = '0;
    end
  end

  // Valid bit is reset; the payload is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      sec_out.valid <= 1'b0;
    end else begin
      sec_out.valid <= in_valid;
    end
    sec_out.sector <= sector_next;
    sec_out.frac   <= FracW'(hue_wrap - base);
    sec_out.sat    <= saturation;
    sec_out.val    <= brightness;
  end

endmodule

/* rtl/hsv2rgb_arith.sv */
module hsv2rgb_arith
  import hsv2rgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  sec_item_t sec_in,
  output lvl_item_t lvl_out
);

  // First stage: saturation products and the numerator of p.
  logic             a_valid;
  logic [SecW-1:0]  a_sector;
  logic [ChanW-1:0] a_val;
  logic [SfW-1:0]   a_sf;
  logic [SfW-1:0]   a_sc;
  logic [PNumW-1:0] a_pnum;

  // Second stage: numerators of q and t.
  logic             b_valid;
  logic [SecW-1:0]  b_sector;
  logic [ChanW-1:0] b_val;
  logic [PNumW-1:0] b_pnum;
  logic [QNumW-1:0] b_qnum;
  logic [QNumW-1:0] b_tnum;

  // Reciprocal products of the last stage.
  logic [PProdW-1:0] p_prod;
  logic [QProdW-1:0] q_prod;
  logic [QProdW-1:0] t_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= sec_in.valid;
      b_valid <= a_valid;
    end
  end

  // S times the fraction, S times its complement, and V times (255 - S).
  always_ff @(posedge clk) begin
    a_sector <= sec_in.sector;
    a_val    <= sec_in.val;
    a_sf     <= SfW'(sec_in.sat) * SfW'(sec_in.frac);
    a_sc     <= SfW'(sec_in.sat) * SfW'(FracW'(SectorDeg) - sec_in.frac);
    a_pnum   <= PNumW'(sec_in.val) * PNumW'(ChanW'(FullScale) - sec_in.sat);
  end

  // V times (15300 - S*fr) and V times (15300 - S*(60 - fr)).
  always_ff @(posedge clk) begin
    b_sector <= a_sector;
    b_val    <= a_val;
    b_pnum   <= a_pnum;
    b_qnum   <= QNumW'(a_val) * QNumW'(SfW'(SectorScale) - a_sf);
    b_tnum   <= QNumW'(a_val) * QNumW'(SfW'(SectorScale) - a_sc);
  end

  // Exact truncating division by constants through scaled reciprocals.
  assign p_prod = PProdW'(b_pnum) * PProdW'(PRecip);
  assign q_prod = QProdW'(b_qnum) * QProdW'(QRecip);
  assign t_prod = QProdW'(b_tnum) * QProdW'(QRecip);

  // Output stage; only its valid bit is reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_out.valid <= 1'b0;
    end else begin
      lvl_out.valid <= b_valid;
    end
    lvl_out.sector <= b_sector;
    lvl_out.val    <= b_val;
    lvl_out.p      <= p_prod[PShift +: ChanW];
    lvl_out.q      <= q_prod[QShift +: ChanW];
    lvl_out.t      <= t_prod[QShift +: ChanW];
  end

endmodule

/* rtl/hsv2rgb_select.sv */
module hsv2rgb_select
  import hsv2rgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  lvl_item_t        lvl_in,
  output logic             done,
  output logic [ChanW-1:0] red,
  output logic [ChanW-1:0] green,
  output logic [ChanW-1:0] blue
);

  logic [ChanW-1:0] red_next;
  logic [ChanW-1:0] green_next;
  logic [ChanW-1:0] blue_next;

  // Pick each channel from V, p, q or t by sector.
  always_comb begin
    unique case (lvl_in.sector)
      SEC_0: begin
        red_next = lvl_in.val; green_next = lvl_in.t;   blue_next = lvl_in.p;
      end
      SEC_1: begin
        red_next = lvl_in.q;   green_next = lvl_in.val; blue_next = lvl_in.p;
      end
      SEC_2: begin
        red_next = lvl_in.p;   green_next = lvl_in.val; blue_next = lvl_in.t;
      end
      SEC_3: begin
        red_next = lvl_in.p;   green_next = lvl_in.q;   blue_next = lvl_in.val;
      end
      SEC_4: begin
        red_next = lvl_in.t;   green_next = lvl_in.p;   blue_next = lvl_in.val;
      end
      default: begin
        red_next = lvl_in.val; green_next = lvl_in.p;   blue_next = lvl_in.q;
      end
    endcase
  end

  // Output register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lvl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

endmodule

/* rtl/hsv_to_rgb_converter_top.sv */
// HSV to RGB colour converter.
// Input: an item is taken at a rising edge where start is high and busy is
// low. busy is held low at all times, so a new item may be given every cycle.
// Each item carries hue (degrees, values of 360 and above wrap round),
// saturation and brightness, both 8-bit fractions where 255 means 1.0.
// Output: red, green and blue appear for exactly one cycle with done high.
// Throughput is one item per clock. The five register stages are sector
// split, saturation products, level numerators, reciprocal multiplication
// and channel selection; the widest multiplier (22 by 23 bits) sets the
// clock.
// Results leave in the order items entered. The receiver cannot hold results
// off, so the pipeline never stalls. A synchronous reset clears every valid
// bit; items in flight at reset are dropped and no strobe follows.
module hsv_to_rgb_converter_top
  import hsv2rgb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [HueW-1:0]  hue,
  input  logic [ChanW-1:0] saturation,
  input  logic [ChanW-1:0] brightness,
  output logic             done,
  output logic [ChanW-1:0] red,
  output logic [ChanW-1:0] green,
  output logic [ChanW-1:0] blue
);

  sec_item_t sec_item;
  lvl_item_t lvl_item;

  // The pipeline never stalls, so an item is always accepted.
  assign busy = 1'b0;

  hsv2rgb_sector u_sector (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start && !busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .sec_out    (sec_item)
  );

  hsv2rgb_arith u_arith (
    .clk     (clk),
    .rst     (rst),
    .sec_in  (sec_item),
    .lvl_out (lvl_item)
  );

  hsv2rgb_select u_select (
    .clk    (clk),
    .rst    (rst),
    .lvl_in (lvl_item),
    .done   (done),
    .red    (red),
    .green  (green),
    .blue   (blue)
  );

  // Every accepted item gives exactly one strobe, and no strobe comes without one.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst, 1) && !$past(rst, 2) && !$past(rst, 3) && !$past(rst, 4) &&
     !$past(rst, 5)) |-> (done == $past(start, 5)))
    else $error("strobe does not follow an accepted item by five cycles");

  // Zero saturation gives grey at the brightness.
  a_grey: assert property (@(posedge clk) disable iff (rst)
    (done && $past(saturation, 5) == '0) |->
      (red == $past(brightness, 5) && green == $past(brightness, 5) &&
       blue == $past(brightness, 5)))
    else $error("zero saturation did not give grey");

  // One channel always carries the brightness itself.
  a_value: assert property (@(posedge clk) disable iff (rst)
    done |-> (red == $past(brightness, 5) || green == $past(brightness, 5) ||
              blue == $past(brightness, 5)))
    else $error("no channel equals the brightness");

endmodule

/* test/hsv_to_rgb_converter_top_tb.sv */
`timescale 1ns / 100ps

module hsv_to_rgb_converter_top_tb;
  import hsv2rgb_pkg::*;

  // One colour as it goes in, and the channels expected back.
  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] val;
  } hsv_item_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_colour_t;

  localparam int RandomItems = 1800;
  localparam int IdleLimit   = 300;
  localparam int DrainCycles = 12;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] saturation;
  logic [ChanW-1:0] brightness;
  logic             done;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  hsv_item_t   pending_colours[$];
  rgb_colour_t expected_rgb[$];
  hsv_item_t   next_colour;
  rgb_colour_t want;

  int total_items;
  int directed_items;
  int items_accepted;
  int colours_checked;
  int grey_items;
  int wrapped_items;
  int fail_count;
  int idle_cycles;
  int burst_left;
  int gap_left;

  hsv_to_rgb_converter_top DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Expected channels for one colour, computed exactly in integers with
  // truncation, as the block is meant to.
  function automatic rgb_colour_t predict_rgb(input logic [HueW-1:0] h,
                                              input logic [ChanW-1:0] s,
                                              input logic [ChanW-1:0] v);
    int unsigned     deg;
    int unsigned     fr;
    int unsigned     sv;
    int unsigned     vv;
    int unsigned     lvl_p;
    int unsigned     lvl_q;
    int unsigned     lvl_t;
    logic [SecW-1:0] sector;
    rgb_colour_t     c;
    deg = h;
    sv  = s;
    vv  = v;
    // Hues past a full turn wrap round the colour circle.
    if (deg >= FullCircle) begin
      deg = deg - FullCircle;
    end
    if (sv == 0) begin
      c.red   = v;
      c.green = v;
      c.blue  = v;
      return c;
    end
    sector = SecW'(deg / SectorDeg);
    fr     = deg % SectorDeg;
    lvl_p  = (vv * (FullScale - sv)) / FullScale;
    lvl_q  = (vv * (SectorScale - sv * fr)) / SectorScale;
    lvl_t  = (vv * (SectorScale - sv * (SectorDeg - fr))) / SectorScale;
    case (sector)
      SEC_0: begin
        c = {v, ChanW'(lvl_t), ChanW'(lvl_p)};
      end
      SEC_1: begin
        c = {ChanW'(lvl_q), v, ChanW'(lvl_p)};
      end
      SEC_2: begin
        c = {ChanW'(lvl_p), v, ChanW'(lvl_t)};
      end
      SEC_3: begin
        c = {ChanW'(lvl_p), ChanW'(lvl_q), v};
      end
      SEC_4: begin
        c = {ChanW'(lvl_t), ChanW'(lvl_p), v};
      end
      // The last sector, from 300 degrees up.
      default: begin
        c = {v, ChanW'(lvl_p), ChanW'(lvl_q)};
      end
    endcase
    return c;
  endfunction

  // A saturation or brightness level that lands on the extremes often.
  function automatic logic [ChanW-1:0] random_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return ChanW'($urandom_range(1, 3));
      default: return ChanW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_colour(input int h, input int s, input int v);
    hsv_item_t it;
    it.hue = HueW'(h);
    it.sat = ChanW'(s);
    it.val = ChanW'(v);
    pending_colours.push_back(it);
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Driver: sends items in bursts of random length with random gaps, and
  // records the expected channels of each item at the edge that takes it.
  always @(posedge clk) begin
    if (rst) begin
      start      <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      if (start && !busy) begin
        expected_rgb.push_back(predict_rgb(hue, saturation, brightness));
        items_accepted++;
        if (saturation == 0) begin
          grey_items++;
        end
        if (hue >= FullCircle) begin
          wrapped_items++;
        end
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_colours.size() > 0) begin
          next_colour = pending_colours.pop_front();
          hue        <= next_colour.hue;
          saturation <= next_colour.sat;
          brightness <= next_colour.val;
          start      <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rgb.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0d/%0d with no item outstanding",
                                  red, green, blue));
      end else begin
        want = expected_rgb.pop_front();
        colours_checked++;
        if (red !== want.red) begin
          report_mismatch($sformatf("red got %0d want %0d", red, want.red));
        end
        if (green !== want.green) begin
          report_mismatch($sformatf("green got %0d want %0d", green, want.green));
        end
        if (blue !== want.blue) begin
          report_mismatch($sformatf("blue got %0d want %0d", blue, want.blue));
        end
      end
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout: nothing accepted for %0d cycles", IdleLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    hue             = '0;
    saturation      = '0;
    brightness      = '0;
    items_accepted  = 0;
    colours_checked = 0;
    grey_items      = 0;
    wrapped_items   = 0;
    fail_count      = 0;
    idle_cycles     = 0;

    // Grey at any hue, including a wrapped one.
    queue_colour(0, 0, 255);
    queue_colour(200, 0, 77);
    queue_colour(511, 0, 0);
    // The start of every sector at full saturation and brightness.
    for (int k = 0; k < 6; k++) begin
      queue_colour(k * SectorDeg, 255, 255);
    end
    // The far edges of sectors.
    queue_colour(59, 200, 180);
    queue_colour(359, 200, 180);
    // Hues past a full turn.
    queue_colour(360, 255, 200);
    queue_colour(511, 255, 200);
    queue_colour(419, 255, 200);
    // Extremes of saturation and brightness, and two mid-range colours.
    queue_colour(30, 255, 0);
    queue_colour(45, 1, 255);
    queue_colour(1, 255, 255);
    queue_colour(150, 128, 128);
    queue_colour(256, 170, 85);
    directed_items = pending_colours.size();

    // Random colours; now and then a hue that needs wrapping.
    for (int k = 0; k < RandomItems; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        queue_colour($urandom_range(FullCircle, 511), random_level(), random_level());
      end else begin
        queue_colour($urandom_range(0, FullCircle - 1), random_level(), random_level());
      end
    end
    total_items = pending_colours.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (items_accepted < total_items) @(posedge clk);
    while (expected_rgb.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    while (expected_rgb.size() != 0) begin
      want = expected_rgb.pop_front();
      report_mismatch($sformatf("no result for expected %0d/%0d/%0d",
                                want.red, want.green, want.blue));
    end

    $display("Covered %0d colours (%0d directed), %0d results checked.",
             items_accepted, directed_items, colours_checked);
    $display("Of these %0d were grey and %0d had a hue past a full turn.",
             grey_items, wrapped_items);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_sector.sv
rtl/hsv2rgb_arith.sv
rtl/hsv2rgb_select.sv
rtl/hsv_to_rgb_converter_top.sv
test/hsv_to_rgb_converter_top_tb.sv
